// ===== rtl/encoder_angle_tracker_defines.svh =====
// Assertion macros shared by the encoder angle tracker RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef ENCODER_ANGLE_TRACKER_DEFINES_SVH
`define ENCODER_ANGLE_TRACKER_DEFINES_SVH

`ifndef SYNTH
// prop must hold at every clock edge outside reset
`define EAT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expr must never be true outside reset
`define EAT_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define EAT_ASSERT(lbl, prop, msg)
`define EAT_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// ===== rtl/eat_pkg.sv =====
// Shared types and constants for the encoder angle tracker.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package eat_pkg;

    localparam int FRAME_W     = 16;
    localparam int RAW_W       = 14;
    localparam int ANG_W       = 16;
    localparam int DELTA_W     = 17;
    localparam int TURN_W      = 16;
    localparam int MULTI_W     = 32;
    localparam int PP_W        = 7;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // 0.8 turn in 1/65536 units
    localparam logic signed [DELTA_W-1:0] JUMP_LIMIT = 17'sd52428;
    localparam logic signed [TURN_W-1:0]  TURN_MAX   = 16'sh7FFF;
    localparam logic signed [TURN_W-1:0]  TURN_MIN   = 16'sh8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIRECTION   = 4'd0,
        REG_POLE_PAIRS  = 4'd1,
        REG_MECH_OFFSET = 4'd2,
        REG_ELEC_OFFSET = 4'd3
    } cfg_reg_e;

    typedef struct packed {
        logic              direction;
        logic [PP_W-1:0]   pole_pairs;
        logic [ANG_W-1:0]  mech_offset;
        logic [ANG_W-1:0]  elec_offset;
    } cfg_t;

    // one classified frame on its way from front to back
    typedef struct packed {
        logic [RAW_W-1:0] raw;
        logic             perr;
        logic [ANG_W-1:0] mech;
    } item_t;

endpackage

// ===== rtl/eat_front.sv =====
// Front end: parity check, count extraction, direction and scaling to 16 bits.
// Depends on eat_pkg.
`timescale 1ns / 1ps

module eat_front #(
    parameter int ANGLE_BITS = 14
) (
    input  logic [eat_pkg::FRAME_W-1:0] rx_frame,
    input  logic                        direction,
    output eat_pkg::item_t              item
);

    localparam int CNT_BITS = (ANGLE_BITS < eat_pkg::RAW_W) ? ANGLE_BITS : eat_pkg::RAW_W;
    localparam int SHIFT    = eat_pkg::ANG_W - ANGLE_BITS;
    localparam logic [eat_pkg::RAW_W-1:0] CNT_MASK = eat_pkg::RAW_W'((1 << CNT_BITS) - 1);

    logic                        perr;
    logic [eat_pkg::RAW_W-1:0]   raw;
    logic [ANGLE_BITS-1:0]       pos_fwd;
    logic [ANGLE_BITS-1:0]       pos;

    always_comb
    begin
        // even parity: bit 15 must equal the xor of bits 14..0
        perr    = rx_frame[15] ^ (^rx_frame[14:0]);
        raw     = perr ? '0 : (rx_frame[eat_pkg::RAW_W-1:0] & CNT_MASK);
        pos_fwd = ANGLE_BITS'(raw);
        // reversal wraps mod one turn, so zero stays zero
        pos     = direction ? pos_fwd : (ANGLE_BITS'(0) - pos_fwd);
        item.raw  = raw;
        item.perr = perr;
        item.mech = eat_pkg::ANG_W'(pos) << SHIFT;
    end

endmodule

// ===== rtl/eat_queue.sv =====
// Short request queue between front and back ends.
// Depends on eat_pkg and the shared assertion header.
`timescale 1ns / 1ps
`include "encoder_angle_tracker_defines.svh"

module eat_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  eat_pkg::item_t wr_item,
    output logic           full,
    input  logic           rd_en,
    output eat_pkg::item_t head,
    output logic           head_valid
);

    eat_pkg::item_t                    entry_reg [eat_pkg::QUEUE_DEPTH];
    logic [eat_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [eat_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [eat_pkg::QPTR_W:0]          cnt_reg, cnt_next;
    logic                              do_wr, do_rd;

    always_comb
    begin
        full       = (cnt_reg == (eat_pkg::QPTR_W+1)'(eat_pkg::QUEUE_DEPTH));
        head_valid = (cnt_reg != '0);
        head       = entry_reg[rd_ptr_reg];
        do_wr      = wr_en && !full;
        do_rd      = rd_en && head_valid;
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

    `EAT_ASSERT_NEVER(a_cnt_bound, cnt_reg > (eat_pkg::QPTR_W+1)'(eat_pkg::QUEUE_DEPTH), "queue count overflow")
    `EAT_ASSERT(a_cnt_inc, (do_wr && !do_rd) |=> (cnt_reg == $past(cnt_reg) + 1'b1), "push lost")
    `EAT_ASSERT(a_cnt_dec, (do_rd && !do_wr) |=> (cnt_reg == $past(cnt_reg) - 1'b1), "pop lost")

endmodule

// ===== rtl/eat_back.sv =====
// Back end: offsets, electrical angle, delta, revolution tracking, result register.
// Depends on eat_pkg and the shared assertion header.
`timescale 1ns / 1ps
`include "encoder_angle_tracker_defines.svh"

module eat_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  eat_pkg::cfg_t                      cfg,
    input  eat_pkg::item_t                     head,
    input  logic                               head_valid,
    output logic                               take,
    output logic                               empty,
    input  logic                               pop,
    output logic [eat_pkg::RAW_W-1:0]          raw_angle,
    output logic                               parity_error,
    output logic [eat_pkg::ANG_W-1:0]          mech_angle,
    output logic [eat_pkg::ANG_W-1:0]          single_angle,
    output logic [eat_pkg::ANG_W-1:0]          elec_angle,
    output logic signed [eat_pkg::DELTA_W-1:0] angle_delta,
    output logic signed [eat_pkg::TURN_W-1:0]  turn_count,
    output logic signed [eat_pkg::MULTI_W-1:0] multi_turn_position
);

    localparam int PROD_W = eat_pkg::ANG_W + eat_pkg::PP_W;

    logic                               out_valid_reg, out_valid_next;
    logic [eat_pkg::ANG_W-1:0]          prev_reg;
    logic signed [eat_pkg::TURN_W-1:0]  rev_reg, rev_next;
    logic signed [eat_pkg::DELTA_W-1:0] delta;
    logic [PROD_W-1:0]                  prod;
    logic [eat_pkg::ANG_W-1:0]          single_next, elec_next;

    logic [eat_pkg::RAW_W-1:0]          raw_reg;
    logic                               perr_reg;
    logic [eat_pkg::ANG_W-1:0]          mech_reg, single_reg, elec_reg;
    logic signed [eat_pkg::DELTA_W-1:0] delta_reg;
    logic signed [eat_pkg::TURN_W-1:0]  turn_reg;

    always_comb
    begin
        take  = head_valid && (!out_valid_reg || pop);
        out_valid_next = take || (out_valid_reg && !pop);
        delta = $signed({1'b0, head.mech}) - $signed({1'b0, prev_reg});
        rev_next = rev_reg;
        // backward wrap shows as a large positive jump, forward as negative
        if (delta > eat_pkg::JUMP_LIMIT)
        begin
            if (rev_reg != eat_pkg::TURN_MIN)
            begin
                rev_next = rev_reg - 16'sd1;
            end
        end
        else if (delta < -eat_pkg::JUMP_LIMIT)
        begin
            if (rev_reg != eat_pkg::TURN_MAX)
            begin
                rev_next = rev_reg + 16'sd1;
            end
        end
        prod        = PROD_W'(head.mech) * PROD_W'(cfg.pole_pairs);
        single_next = head.mech + cfg.mech_offset;
        elec_next   = prod[eat_pkg::ANG_W-1:0] + cfg.elec_offset;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            prev_reg      <= '0;
            rev_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                prev_reg <= head.mech;
                rev_reg  <= rev_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            raw_reg    <= head.raw;
            perr_reg   <= head.perr;
            mech_reg   <= head.mech;
            single_reg <= single_next;
            elec_reg   <= elec_next;
            delta_reg  <= delta;
            turn_reg   <= rev_next;
        end
    end

    assign empty               = !out_valid_reg;
    assign raw_angle           = raw_reg;
    assign parity_error        = perr_reg;
    assign mech_angle          = mech_reg;
    assign single_angle        = single_reg;
    assign elec_angle          = elec_reg;
    assign angle_delta         = delta_reg;
    assign turn_count          = turn_reg;
    assign multi_turn_position = {turn_reg, mech_reg};

    `EAT_ASSERT(a_rev_step, take |=> ((rev_reg == $past(rev_reg)) || (rev_reg == $past(rev_reg) + 16'sd1) || (rev_reg == $past(rev_reg) - 16'sd1)), "revolution count jumped by more than one")
    `EAT_ASSERT(a_state_hold, !take |=> ($stable(rev_reg) && $stable(prev_reg)), "tracking state changed without a request")
    `EAT_ASSERT(a_take_shows, take |=> (out_valid_reg && (turn_reg == rev_reg) && (mech_reg == prev_reg)), "result register out of step with tracking state")

endmodule

// ===== rtl/encoder_angle_tracker.sv =====
// Top level of the encoder angle tracker: configuration registers, front, queue, back.
// Depends on eat_pkg, eat_front, eat_queue and eat_back.
//
//  channel   handshake           payload
//  --------  ------------------  ----------------------------------------------
//  config    cfg_valid/cfg_ready cfg_index, cfg_data
//  input     push/full           rx_frame
//  result    empty/pop           raw_angle .. multi_turn_position (eight fields)
//
// One frame per cycle sustained while results are popped; an accepted frame is written
// into the queue at its edge and loaded into the result register from the queue head once
// that register is empty or popped. The revolution count update in the back end is a loop.
// A 4-deep queue decouples front and back; full rises only when results are not popped.
// Reset empties queue and result register, clears previous angle and revolution count,
// and loads the configuration defaults. cfg_ready is always high.
`timescale 1ns / 1ps

module encoder_angle_tracker #(
    parameter int ANGLE_BITS = 14
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [eat_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [eat_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  push,
    output logic                                  full,
    input  logic [eat_pkg::FRAME_W-1:0]           rx_frame,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [eat_pkg::RAW_W-1:0]             raw_angle,
    output logic                                  parity_error,
    output logic [eat_pkg::ANG_W-1:0]             mech_angle,
    output logic [eat_pkg::ANG_W-1:0]             single_angle,
    output logic [eat_pkg::ANG_W-1:0]             elec_angle,
    output logic signed [eat_pkg::DELTA_W-1:0]    angle_delta,
    output logic signed [eat_pkg::TURN_W-1:0]     turn_count,
    output logic signed [eat_pkg::MULTI_W-1:0]    multi_turn_position
);

    eat_pkg::cfg_t  cfg_reg;
    eat_pkg::item_t front_item;
    eat_pkg::item_t head;
    logic           head_valid;
    logic           take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.direction   <= 1'b1;
            cfg_reg.pole_pairs  <= 7'd7;
            cfg_reg.mech_offset <= 16'd19042;
            cfg_reg.elec_offset <= 16'd2218;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (eat_pkg::cfg_reg_e'(cfg_index))
                eat_pkg::REG_DIRECTION:   cfg_reg.direction   <= cfg_data[0];
                eat_pkg::REG_POLE_PAIRS:  cfg_reg.pole_pairs  <= cfg_data[eat_pkg::PP_W-1:0];
                eat_pkg::REG_MECH_OFFSET: cfg_reg.mech_offset <= cfg_data;
                eat_pkg::REG_ELEC_OFFSET: cfg_reg.elec_offset <= cfg_data;
                default:                  cfg_reg             <= cfg_reg;
            endcase
        end
    end

    eat_front #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .rx_frame  (rx_frame),
        .direction (cfg_reg.direction),
        .item      (front_item)
    );

    eat_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (push),
        .wr_item    (front_item),
        .full       (full),
        .rd_en      (take),
        .head       (head),
        .head_valid (head_valid)
    );

    eat_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg                 (cfg_reg),
        .head                (head),
        .head_valid          (head_valid),
        .take                (take),
        .empty               (empty),
        .pop                 (pop),
        .raw_angle           (raw_angle),
        .parity_error        (parity_error),
        .mech_angle          (mech_angle),
        .single_angle        (single_angle),
        .elec_angle          (elec_angle),
        .angle_delta         (angle_delta),
        .turn_count          (turn_count),
        .multi_turn_position (multi_turn_position)
    );

endmodule
